[design/bse_pkg.sv]
package bse_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int OUT_BITS = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [1:0] MODE_SCREEN = 2'd0;
  localparam logic [1:0] MODE_EYE    = 2'd1;
  localparam logic [1:0] MODE_FLAT   = 2'd2;
  localparam logic [1:0] MODE_CUSTOM = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_AXIS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_AXIS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_EYE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SYSTEM_OFFSET = 3'd4;

  localparam int IN_TDATA_W = 64;
  localparam int OUT_TDATA_W = 104;

  typedef logic signed [16:0] rel_t;
  typedef logic signed [17:0] vec_t;

  typedef struct packed {
    rel_t        rx;
    rel_t        ry;
    rel_t        rz;
    vec_t        fx;
    vec_t        fy;
    vec_t        fz;
    logic [15:0] size;
  } job_t;

  typedef enum logic [3:0] {
    B_IDLE, B_LOAD, B_SQ, B_DINIT, B_DIV, B_SINIT, B_SQRT, B_STORE,
    B_PEND, B_MUL, B_EMIT
  } back_state_t;

  // shift right by 14, round half away from zero
  function automatic logic signed [22:0] rnd14(input logic signed [36:0] x);
    logic [36:0] m;
    logic [36:0] t;
    m = x[36] ? 37'(-x) : 37'(x);
    t = (m + 37'd8192) >> 14;
    return x[36] ? -23'(t) : 23'(t);
  endfunction

  function automatic logic [15:0] sat_out(input logic signed [21:0] v);
    logic signed [21:0] hi;
    logic signed [21:0] lo;
    logic signed [21:0] r;
    hi = 22'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
    lo = -hi - 22'sd1;
    r = v;
    if (v > hi) r = hi;
    if (v < lo) r = lo;
    return r[15:0];
  endfunction

endpackage

[design/bse_front.sv]
module bse_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bse_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bse_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bse_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic                              q_full,
  output logic                              q_push,
  output bse_pkg::job_t                     q_wdata
);

  logic [1:0]  align_mode;
  logic [47:0] custom_axis;
  logic [47:0] camera_axis;
  logic [47:0] camera_eye;
  logic [47:0] system_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      align_mode    <= bse_pkg::MODE_SCREEN;
      custom_axis   <= 48'd256;
      camera_axis   <= '0;
      camera_eye    <= '0;
      system_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bse_pkg::REG_ALIGN_MODE:    align_mode    <= cfg_data[1:0];
        bse_pkg::REG_CUSTOM_AXIS:   custom_axis   <= cfg_data;
        bse_pkg::REG_CAMERA_AXIS:   camera_axis   <= cfg_data;
        bse_pkg::REG_CAMERA_EYE:    camera_eye    <= cfg_data;
        bse_pkg::REG_SYSTEM_OFFSET: system_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  logic signed [15:0] pos [3];
  logic signed [15:0] off [3];
  logic signed [15:0] cax [3];
  logic signed [15:0] eye [3];
  logic signed [15:0] cus [3];
  bse_pkg::rel_t      rel [3];
  bse_pkg::vec_t      f   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos[i] = s_tdata[16*i +: 16];
      off[i] = system_offset[16*i +: 16];
      cax[i] = camera_axis[16*i +: 16];
      eye[i] = camera_eye[16*i +: 16];
      cus[i] = custom_axis[16*i +: 16];
      rel[i] = 17'(pos[i]) - 17'(off[i]);
      case (align_mode)
        bse_pkg::MODE_SCREEN: f[i] = -18'(cax[i]);
        bse_pkg::MODE_EYE,
        bse_pkg::MODE_FLAT:   f[i] = 18'(eye[i]) - 18'(rel[i]);
        default:              f[i] = 18'(cus[i]);
      endcase
    end
    if (align_mode == bse_pkg::MODE_FLAT) f[2] = '0;
    q_wdata.rx   = rel[0];
    q_wdata.ry   = rel[1];
    q_wdata.rz   = rel[2];
    q_wdata.fx   = f[0];
    q_wdata.fy   = f[1];
    q_wdata.fz   = f[2];
    q_wdata.size = s_tdata[63:48];
  end

endmodule

[design/bse_fifo.sv]
module bse_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bse_pkg::job_t wdata,
  input  logic          pop,
  output bse_pkg::job_t rdata,
  output logic          full,
  output logic          empty
);

  bse_pkg::job_t mem [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 2'd1;
      if (pop)  rptr <= rptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

  assign rdata = mem[rptr];
  assign full  = (count == 3'd4);
  assign empty = (count == 3'd0);

endmodule

[design/bse_back.sv]
module bse_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_empty,
  input  bse_pkg::job_t                      q_rdata,
  output logic                               q_pop,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [bse_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                               m_tlast
);

  bse_pkg::back_state_t state, state_next;

  bse_pkg::rel_t      rel [3];
  logic [15:0]        size;
  bse_pkg::vec_t      vec [3];
  logic [15:0]        mag [3];
  logic               neg [3];
  logic [31:0]        sq  [3];
  logic [33:0]        l2;
  logic signed [15:0] res [3];
  logic signed [15:0] d   [3];
  logic signed [15:0] p1  [3];
  logic signed [17:0] p2  [3];
  logic signed [19:0] a   [3];
  logic signed [19:0] b   [3];
  logic               pass;
  logic [1:0]         comp;
  logic [4:0]         cnt;
  logic [3:0]         k;
  logic [33:0]        rem;
  logic [28:0]        q;
  logic [28:0]        x;
  logic [29:0]        r;
  logic [3:0]         step;
  logic signed [35:0] prod;
  logic signed [35:0] acc;
  logic [1:0]         cidx;
  logic               load;

  // absolute values and range reduction for the normalizer
  logic [17:0] absv [3];
  logic [17:0] shv  [3];
  logic        any17, any16, all_zero;

  always_comb begin
    any17 = 1'b0;
    any16 = 1'b0;
    all_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      absv[i] = vec[i][17] ? 18'(-vec[i]) : 18'(vec[i]);
      any17 = any17 | absv[i][17];
      any16 = any16 | absv[i][16];
      all_zero = all_zero & (absv[i] == 18'd0);
    end
    for (int i = 0; i < 3; i++) begin
      shv[i] = any17 ? (absv[i] >> 2) : (any16 ? (absv[i] >> 1) : absv[i]);
    end
  end

  logic [31:0] sq_now;
  assign sq_now = 32'(mag[comp]) * 32'(mag[comp]);

  logic [34:0] rem2;
  assign rem2 = {rem, 1'b0};

  logic [29:0] sbit;
  logic [29:0] trial;
  assign sbit  = 30'd1 << {k, 1'b0};
  assign trial = r + sbit;

  logic [14:0] root;
  assign root = (r > 30'd16384) ? 15'd16384 : r[14:0];

  // shared multiplier operands
  logic signed [17:0] ma, mb;
  logic signed [17:0] szs;
  assign szs = 18'($signed({2'b00, size}));

  always_comb begin
    ma = '0;
    mb = '0;
    case (step)
      4'd0: begin ma = 18'(d[2]);  mb = 18'(p1[1]); end
      4'd1: begin ma = 18'(d[2]);  mb = 18'(p1[0]); end
      4'd2: begin ma = 18'(d[0]);  mb = 18'(p1[1]); end
      4'd3: begin ma = 18'(d[1]);  mb = 18'(p1[0]); end
      4'd4: begin ma = 18'(p1[0]); mb = szs; end
      4'd5: begin ma = 18'(p1[1]); mb = szs; end
      4'd6: begin ma = 18'(p1[2]); mb = szs; end
      4'd7: begin ma = p2[0];      mb = szs; end
      4'd8: begin ma = p2[1];      mb = szs; end
      4'd9: begin ma = p2[2];      mb = szs; end
      default: ;
    endcase
  end

  logic signed [22:0] rp;
  logic signed [22:0] rn;
  logic signed [22:0] rd;
  assign rp = bse_pkg::rnd14(37'(prod));
  assign rn = bse_pkg::rnd14(-37'(prod));
  assign rd = bse_pkg::rnd14(37'(acc) - 37'(prod));

  always_comb begin
    state_next = state;
    case (state)
      bse_pkg::B_IDLE:  if (!q_empty) state_next = bse_pkg::B_LOAD;
      bse_pkg::B_LOAD:  state_next = all_zero ? bse_pkg::B_PEND : bse_pkg::B_SQ;
      bse_pkg::B_SQ:    if (comp == 2'd2) state_next = bse_pkg::B_DINIT;
      bse_pkg::B_DINIT: state_next = bse_pkg::B_DIV;
      bse_pkg::B_DIV:   if (cnt == 5'd27) state_next = bse_pkg::B_SINIT;
      bse_pkg::B_SINIT: state_next = bse_pkg::B_SQRT;
      bse_pkg::B_SQRT:  if (k == 4'd0) state_next = bse_pkg::B_STORE;
      bse_pkg::B_STORE: state_next = (comp == 2'd2) ? bse_pkg::B_PEND : bse_pkg::B_DINIT;
      bse_pkg::B_PEND:  state_next = pass ? bse_pkg::B_MUL : bse_pkg::B_LOAD;
      bse_pkg::B_MUL:   if (step == 4'd10) state_next = bse_pkg::B_EMIT;
      bse_pkg::B_EMIT:  if (load && k[1:0] == 2'd3) state_next = bse_pkg::B_IDLE;
      default:          state_next = bse_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == bse_pkg::B_IDLE) && !q_empty;
    load  = (state == bse_pkg::B_EMIT) && (!m_tvalid || m_tready);
    cidx  = k[1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bse_pkg::B_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      bse_pkg::B_IDLE: begin
        rel[0] <= q_rdata.rx;
        rel[1] <= q_rdata.ry;
        rel[2] <= q_rdata.rz;
        vec[0] <= q_rdata.fx;
        vec[1] <= q_rdata.fy;
        vec[2] <= q_rdata.fz;
        size   <= q_rdata.size;
        pass   <= 1'b0;
      end
      bse_pkg::B_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          mag[i] <= shv[i][15:0];
          neg[i] <= vec[i][17];
          res[i] <= '0;
        end
        l2   <= '0;
        comp <= '0;
      end
      bse_pkg::B_SQ: begin
        sq[comp] <= sq_now;
        l2 <= l2 + 34'(sq_now);
        comp <= (comp == 2'd2) ? 2'd0 : comp + 2'd1;
      end
      bse_pkg::B_DINIT: begin
        if (34'(sq[comp]) >= l2) begin
          q   <= 29'd1;
          rem <= 34'(sq[comp]) - l2;
        end else begin
          q   <= 29'd0;
          rem <= 34'(sq[comp]);
        end
        cnt <= '0;
      end
      bse_pkg::B_DIV: begin
        if (rem2 >= 35'(l2)) begin
          rem <= 34'(rem2 - 35'(l2));
          q   <= {q[27:0], 1'b1};
        end else begin
          rem <= rem2[33:0];
          q   <= {q[27:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
      end
      bse_pkg::B_SINIT: begin
        x <= q;
        r <= '0;
        k <= 4'd14;
      end
      bse_pkg::B_SQRT: begin
        if (30'(x) >= trial) begin
          x <= 29'(30'(x) - trial);
          r <= (r >> 1) + sbit;
        end else begin
          r <= r >> 1;
        end
        k <= k - 4'd1;
      end
      bse_pkg::B_STORE: begin
        res[comp] <= neg[comp] ? -16'(root) : 16'(root);
        comp <= comp + 2'd1;
      end
      bse_pkg::B_PEND: begin
        if (!pass) begin
          d[0] <= res[0];
          d[1] <= res[1];
          d[2] <= res[2];
          vec[0] <= -18'(res[1]);
          vec[1] <= 18'(res[0]);
          vec[2] <= '0;
          pass <= 1'b1;
        end else begin
          p1[0] <= res[0];
          p1[1] <= res[1];
          p1[2] <= res[2];
          step <= '0;
        end
      end
      bse_pkg::B_MUL: begin
        prod <= ma * mb;
        case (step)
          4'd1:  p2[0] <= 18'(rn);
          4'd2:  p2[1] <= 18'(rp);
          4'd3:  acc   <= prod;
          4'd4:  p2[2] <= 18'(rd);
          4'd5:  a[0]  <= 20'(rp);
          4'd6:  a[1]  <= 20'(rp);
          4'd7:  a[2]  <= 20'(rp);
          4'd8:  b[0]  <= 20'(rp);
          4'd9:  b[1]  <= 20'(rp);
          4'd10: b[2]  <= 20'(rp);
          default: ;
        endcase
        step <= step + 4'd1;
        k <= '0;
      end
      bse_pkg::B_EMIT: begin
        if (load) k <= k + 4'd1;
      end
      default: ;
    endcase
  end

  // corner assembly: 0 = +a-b, 1 = -a-b, 2 = -a+b, 3 = +a+b
  logic               sa, sb;
  logic signed [21:0] cs [3];
  logic [15:0]        cv [3];

  always_comb begin
    sa = (cidx == 2'd0) || (cidx == 2'd3);
    sb = cidx[1];
    for (int i = 0; i < 3; i++) begin
      cs[i] = 22'(rel[i]) + (sa ? 22'(a[i]) : -22'(a[i]))
            + (sb ? 22'(b[i]) : -22'(b[i]));
      cv[i] = bse_pkg::sat_out(cs[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {6'd0, d[2], d[1], d[0], cv[2], cv[1], cv[0], cidx};
      m_tlast <= (cidx == 2'd3);
    end
  end

endmodule

[design/billboard_sprite_expander_unit.sv]
// Billboard sprite expander. Each particle transaction on the s_ side (position and half
// extent) produces four corner transactions on the m_ side, corners 0..3 in order with
// tlast on corner 3, all carrying the same Q2.14 normal. A front stage makes the
// position relative to the system offset and picks the facing vector; a four-entry
// queue hands particles to the back stage, which normalizes twice and scales on a
// single shared divider, square-root and multiplier. A particle holds the back stage
// through two normalizations of 3 components, the multiply steps and the four emits
// before the next one is popped; that loop sets the throughput. Configuration
// writes take effect immediately and must only happen while the unit is idle.
module billboard_sprite_expander_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bse_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bse_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // pos_x, pos_y, pos_z, sprite_size
  input  logic [bse_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // corner, vx, vy, vz, nx, ny, nz, zero pad
  output logic [bse_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                              m_tlast
);

  logic          q_push, q_pop, q_full, q_empty;
  bse_pkg::job_t q_wdata, q_rdata;

  bse_front u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata,
    .q_full, .q_push, .q_wdata
  );

  bse_fifo u_fifo (
    .clk, .rst, .push(q_push), .wdata(q_wdata), .pop(q_pop),
    .rdata(q_rdata), .full(q_full), .empty(q_empty)
  );

  bse_back u_back (
    .clk, .rst, .q_empty, .q_rdata, .q_pop,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

endmodule

[design/bse_checker.sv]
module bse_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [bse_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input logic                              m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[1:0] == 2'd3)))
    else $error("tlast does not match corner 3");

  a_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      !m_tvalid || (m_tdata[1:0] == 2'($past(m_tdata[1:0]) + 2'd1)))
    else $error("corner order broken");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("valid after reset");

endmodule

bind billboard_sprite_expander_unit bse_checker u_bse_checker (
  .clk, .rst, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);
